[rtl/wfm_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// wfm_pkg
// Shared types and constants for the windowed filtered mean block.
// ============================================================================
package wfm_pkg;

    localparam int FRACTION_BITS     = 16;
    localparam int WINDOW_LIMIT_DEF  = 1048576;

    localparam int STAT_W   = 32;
    localparam int SV_W     = FRACTION_BITS + 1;
    localparam int TAG_W    = 16;
    localparam int POS_W    = 32;
    localparam int SITES_W  = 21;
    localparam int SUM_W    = 64;
    localparam int DEN_W    = 37;
    localparam int MIN_W    = 16;
    localparam int CFG_W    = 21;
    localparam int IDX_W    = 2;
    localparam int QUO_W    = 32;
    localparam int STEP_W   = 6;

    localparam logic [SV_W-1:0]  ONE_Q   = SV_W'(1) << FRACTION_BITS;
    localparam logic [DEN_W-1:0] DEN_MAX = '1;

    // register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [IDX_W-1:0] REG_MODE   = 2'd1;
    localparam logic [IDX_W-1:0] REG_MIN    = 2'd2;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_OMIT   = 2'd1,
        MODE_THRESH = 2'd2,
        MODE_WEIGHT = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_FRAC,
        S_FRAC_DIV,
        S_MEAN,
        S_MEAN_DIV,
        S_DONE
    } state_t;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DEN_W-1:0]  rem_init;
        logic [QUO_W-1:0]  bits;
        logic [DEN_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_stat_t;

endpackage

[rtl/wfm_divider.sv]
`timescale 1ns / 1ps
// ============================================================================
// wfm_divider
// Restoring divider, one quotient bit per cycle, shared by the close sequence.
// ============================================================================
module wfm_divider
    import wfm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_req_t  req,
    output div_stat_t stat
);

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  div_reg;
    logic [QUO_W-1:0]  bits_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DEN_W:0] trial;
    logic           ge;

    // partial remainder stays below the divisor, so one extra bit suffices
    always_comb
    begin
        trial    = {rem_reg, bits_reg[QUO_W-1]};
        ge       = trial >= {1'b0, div_reg};
        rem_next = ge ? DEN_W'(trial - {1'b0, div_reg}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.rem_init;
            bits_reg <= req.bits;
            div_reg  <= req.divisor;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            bits_reg <= {bits_reg[QUO_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

[rtl/windowed_filtered_mean.sv]
`timescale 1ns / 1ps
// ============================================================================
// windowed_filtered_mean
// Mean of a per-site statistic over non-overlapping windows of sites.
// ============================================================================
// A site request passes accept, weight and product, and accumulate before the
// next ready. A site that closes a window then runs the close sequence on the
// shared restoring divider, one quotient bit per cycle: 17 quotient bits for
// the usable share and 32 for the mean, skipped where the result saturates
// or the denominator is zero. The finished result sits in an output
// register; the next site is taken while it waits. Configuration registers are
// read while a site is weighted and accumulated, so a write can affect the site in progress.
module windowed_filtered_mean
    import wfm_pkg::*;
#(
    parameter int WINDOW_LIMIT = WINDOW_LIMIT_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,

    input  logic             s_tvalid,
    output logic             s_tready,
    // statistic[31:0], site_value[48:32], sequence_tag[64:49], zero pad
    input  logic [71:0]      s_tdata,
    // statistic_missing
    input  logic             s_tuser,
    input  logic             s_tlast,

    output logic             m_tvalid,
    input  logic             m_tready,
    // first_position[31:0], mean[63:32], usable_share[80:64],
    // window_sum[144:81], window_denominator[181:145], window_sites[202:182],
    // result_tag[218:203], zero pad
    output logic [223:0]     m_tdata,
    // no_mean
    output logic             m_tuser,
    output logic             m_tlast
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] cfg_window_reg;
    mode_t            cfg_mode_reg;
    logic [MIN_W-1:0] cfg_min_reg;

    // accepted site
    logic signed [STAT_W-1:0] stat_reg;
    logic                     miss_reg;
    logic [SV_W-1:0]          sv_reg;
    logic [TAG_W-1:0]         tag_reg;
    logic                     last_reg;

    // per-site contribution
    logic signed [SUM_W-1:0] addend_reg;
    logic [SV_W-1:0]         dadd_reg;

    // running window state
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   start_reg;
    logic [SITES_W-1:0] sites_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [DEN_W-1:0]   den_reg;

    // closed window being worked on
    logic [POS_W-1:0]   win_start_reg;
    logic [SUM_W-1:0]   win_sum_reg;
    logic [DEN_W-1:0]   win_den_reg;
    logic [SITES_W-1:0] win_sites_reg;
    logic [TAG_W-1:0]   win_tag_reg;
    logic               win_last_reg;
    logic [SUM_W-1:0]   mag_reg;
    logic [STAT_W-1:0]  win_mean_reg;
    logic [SV_W-1:0]    win_uf_reg;
    logic               win_nomean_reg;

    // output register
    logic               m_valid_reg;
    logic [POS_W-1:0]   m_start_reg;
    logic [STAT_W-1:0]  m_mean_reg;
    logic [SV_W-1:0]    m_uf_reg;
    logic [SUM_W-1:0]   m_sum_reg;
    logic [DEN_W-1:0]   m_den_reg;
    logic [SITES_W-1:0] m_sites_reg;
    logic [TAG_W-1:0]   m_tag_reg;
    logic               m_nomean_reg;
    logic               m_last_reg;

    div_req_t  div_req;
    div_stat_t div_stat;
    logic      out_load;

    wfm_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_window_reg <= CFG_W'(10000);
            cfg_mode_reg   <= MODE_PLAIN;
            cfg_min_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW: cfg_window_reg <= cfg_data;
                REG_MODE:   cfg_mode_reg   <= mode_t'(cfg_data[1:0]);
                REG_MIN:    cfg_min_reg    <= cfg_data[MIN_W-1:0];
                default:    ;
            endcase
        end
    end

    logic [SITES_W-1:0] wlen;

    always_comb
    begin
        if (cfg_window_reg == '0)
            wlen = SITES_W'(1);
        else if (32'(cfg_window_reg) > 32'(WINDOW_LIMIT))
            wlen = SITES_W'(WINDOW_LIMIT);
        else
            wlen = cfg_window_reg;
    end

    // ------------------------------------------------------------------
    // per-site weight and product
    // ------------------------------------------------------------------
    logic signed [STAT_W-1:0]   stat_eff;
    logic [SV_W-1:0]            w_raw, w_cap, flag_cap;
    logic signed [STAT_W+SV_W:0] prod;
    logic signed [SUM_W-1:0]    addend_next;
    logic [SV_W-1:0]            dadd_next;

    always_comb
    begin
        stat_eff = miss_reg ? '0 : stat_reg;
        w_raw    = miss_reg ? '0 : sv_reg;
        w_cap    = (w_raw > ONE_Q) ? ONE_Q : w_raw;
        flag_cap = (miss_reg || sv_reg > ONE_Q) ? ONE_Q : sv_reg;
        prod     = stat_eff * $signed({1'b0, w_cap});
        addend_next = '0;
        dadd_next   = '0;
        unique case (cfg_mode_reg)
            MODE_PLAIN:
            begin
                addend_next = SUM_W'(stat_eff);
            end
            MODE_OMIT:
            begin
                dadd_next = ONE_Q - flag_cap;
                if (flag_cap == '0)
                    addend_next = SUM_W'(stat_eff);
            end
            MODE_THRESH:
            begin
                if (w_raw > {1'b0, cfg_min_reg})
                begin
                    addend_next = SUM_W'(stat_eff);
                    dadd_next   = ONE_Q;
                end
            end
            MODE_WEIGHT:
            begin
                // arithmetic shift is floor division by ONE
                addend_next = SUM_W'(prod >>> FRACTION_BITS);
                dadd_next   = w_cap;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // accumulate and close test
    // ------------------------------------------------------------------
    logic [SITES_W-1:0] sites_inc;
    logic [SUM_W-1:0]   sum_inc;
    logic [DEN_W:0]     den_wide;
    logic [DEN_W-1:0]   den_inc;
    logic               close;

    always_comb
    begin
        sites_inc = sites_reg + SITES_W'(1);
        sum_inc   = sum_reg + addend_reg;
        den_wide  = {1'b0, den_reg} + (DEN_W+1)'(dadd_reg);
        den_inc   = den_wide[DEN_W] ? DEN_MAX : den_wide[DEN_W-1:0];
        close     = (sites_inc >= wlen) || last_reg;
    end

    // ------------------------------------------------------------------
    // close sequence helpers
    // ------------------------------------------------------------------
    logic              frac_sat;
    logic              mean_sat;
    logic              neg;
    logic [QUO_W-1:0]  lim, val_src, val_cap, mean_fin;
    logic [SV_W-1:0]   uf_q;
    logic [SUM_W-1:0]  mag_next;

    always_comb
    begin
        neg      = win_sum_reg[SUM_W-1];
        mag_next = neg ? (~win_sum_reg + SUM_W'(1)) : win_sum_reg;
        frac_sat = {1'b0, win_den_reg[DEN_W-1:FRACTION_BITS+1]} >= win_sites_reg;
        mean_sat = mag_reg[SUM_W-1:FRACTION_BITS] >= (SUM_W-FRACTION_BITS)'(win_den_reg);
        lim      = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        val_src  = (state_reg == S_MEAN_DIV) ? div_stat.quotient : lim;
        val_cap  = (val_src > lim) ? lim : val_src;
        mean_fin = neg ? (~val_cap + QUO_W'(1)) : val_cap;
        uf_q     = (div_stat.quotient[SV_W-1:0] > ONE_Q) ? ONE_Q
                                                         : div_stat.quotient[SV_W-1:0];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        div_req    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = close ? S_FRAC : S_IDLE;
            end
            S_FRAC:
            begin
                if (win_den_reg == '0)
                    state_next = S_DONE;
                else if (frac_sat)
                    state_next = S_MEAN;
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.steps    = STEP_W'(FRACTION_BITS + 1);
                    div_req.rem_init = DEN_W'(win_den_reg[DEN_W-1:FRACTION_BITS+1]);
                    div_req.bits     = {win_den_reg[FRACTION_BITS:0],
                                        (QUO_W-FRACTION_BITS-1)'(0)};
                    div_req.divisor  = DEN_W'(win_sites_reg);
                    state_next       = S_FRAC_DIV;
                end
            end
            S_FRAC_DIV:
            begin
                if (div_stat.done)
                    state_next = S_MEAN;
            end
            S_MEAN:
            begin
                if (mean_sat)
                    state_next = S_DONE;
                else
                begin
                    // remainder start is below the divisor, so it fits
                    div_req.start    = 1'b1;
                    div_req.steps    = STEP_W'(QUO_W);
                    div_req.rem_init = mag_reg[DEN_W+FRACTION_BITS-1:FRACTION_BITS];
                    div_req.bits     = {mag_reg[FRACTION_BITS-1:0],
                                        (QUO_W-FRACTION_BITS)'(0)};
                    div_req.divisor  = win_den_reg;
                    state_next       = S_MEAN_DIV;
                end
            end
            S_MEAN_DIV:
            begin
                if (div_stat.done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // running window state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            start_reg <= POS_W'(1);
            sites_reg <= '0;
            sum_reg   <= '0;
            den_reg   <= '0;
        end
        else if (state_reg == S_ADD)
        begin
            pos_reg <= pos_reg + POS_W'(1);
            if (sites_reg == '0)
                start_reg <= pos_reg + POS_W'(1);
            if (close)
            begin
                sites_reg <= '0;
                sum_reg   <= '0;
                den_reg   <= '0;
                if (last_reg)
                    pos_reg <= '0;
            end
            else
            begin
                sites_reg <= sites_inc;
                sum_reg   <= sum_inc;
                den_reg   <= den_inc;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            stat_reg <= $signed(s_tdata[31:0]);
            sv_reg   <= s_tdata[48:32];
            tag_reg  <= s_tdata[64:49];
            miss_reg <= s_tuser;
            last_reg <= s_tlast;
        end

        if (state_reg == S_MUL)
        begin
            addend_reg <= addend_next;
            dadd_reg   <= dadd_next;
        end

        if (state_reg == S_ADD && close)
        begin
            win_start_reg <= (sites_reg == '0) ? (pos_reg + POS_W'(1)) : start_reg;
            win_sum_reg   <= sum_inc;
            win_den_reg   <= (cfg_mode_reg == MODE_PLAIN)
                             ? {sites_inc, FRACTION_BITS'(0)} : den_inc;
            win_sites_reg <= sites_inc;
            win_tag_reg   <= tag_reg;
            win_last_reg  <= last_reg;
        end

        if (state_reg == S_FRAC)
        begin
            mag_reg        <= mag_next;
            win_nomean_reg <= (win_den_reg == '0);
            win_mean_reg   <= '0;
            win_uf_reg     <= (win_den_reg == '0) ? '0 : ONE_Q;
        end

        if (state_reg == S_FRAC_DIV && div_stat.done)
            win_uf_reg <= uf_q;

        if ((state_reg == S_MEAN && mean_sat) || (state_reg == S_MEAN_DIV && div_stat.done))
            win_mean_reg <= mean_fin;

        if (out_load)
        begin
            m_start_reg  <= win_start_reg;
            m_mean_reg   <= win_mean_reg;
            m_uf_reg     <= win_uf_reg;
            m_sum_reg    <= win_sum_reg;
            m_den_reg    <= win_den_reg;
            m_sites_reg  <= win_sites_reg;
            m_tag_reg    <= win_tag_reg;
            m_nomean_reg <= win_nomean_reg;
            m_last_reg   <= win_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_nomean_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'b0, m_tag_reg, m_sites_reg, m_den_reg, m_sum_reg,
                       m_uf_reg, m_mean_reg, m_start_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_MUL))
        else $error("accepted request did not enter the multiply step");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_FRAC_DIV || state_reg == S_MEAN_DIV))
        else $error("divider finished outside a divide step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("output register overwritten while a result waits");

    a_no_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_mean_reg == '0 && m_uf_reg == '0))
        else $error("no-mean result carries a nonzero mean or fraction");

endmodule
